>>> hdl/fmpf_pkg.sv
// ---------------------------------------------------------------------------
// fmpf_pkg: shared types and helpers for the first-match packet filter
// Rule layout, request/response items, request and status codes, and the
// circular table address helper.
// ---------------------------------------------------------------------------
package fmpf_pkg;

    // Table size and derived widths
    localparam int MAX_RULES = 64;
    localparam int AW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW        = $clog2(MAX_RULES + 1);

    // Request codes
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        src_ip_any;
        logic        dst_ip_any;
        logic        sport_any;
        logic        dport_any;
        logic        rule_block;
        logic [5:0]  rule_index;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic       verdict_block;
        logic       matched;
        logic [5:0] match_index;
        logic [6:0] rule_count;
        logic [1:0] status;
    } t_out_item;

    // One stored rule (one RAM word)
    typedef struct packed {
        logic        src_ip_any;
        logic [31:0] src_ip;
        logic        dst_ip_any;
        logic [31:0] dst_ip;
        logic        sport_any;
        logic [15:0] sport;
        logic        dport_any;
        logic [15:0] dport;
        logic        block;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    // Build a rule word from an insert request
    function automatic t_rule make_rule(input t_in_item req);
        t_rule r;
        r.src_ip_any = req.src_ip_any;
        r.src_ip     = req.src_ip;
        r.dst_ip_any = req.dst_ip_any;
        r.dst_ip     = req.dst_ip;
        r.sport_any  = req.sport_any;
        r.sport      = req.sport;
        r.dport_any  = req.dport_any;
        r.dport      = req.dport;
        r.block      = req.rule_block;
        return r;
    endfunction

    // Physical RAM address of logical position k, table starts at head
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] k);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, k};
        if (sum >= (AW+1)'(MAX_RULES)) begin
            sum = sum - (AW+1)'(MAX_RULES);
        end
        return sum[AW-1:0];
    endfunction

endpackage

>>> hdl/fmpf_ram.sv
// ---------------------------------------------------------------------------
// fmpf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module fmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/fmpf_match.sv
// ---------------------------------------------------------------------------
// fmpf_match: rule-against-packet comparator
// A rule hits when each of its four fields equals the packet's or is a
// wildcard.
// ---------------------------------------------------------------------------
module fmpf_match (
    input  fmpf_pkg::t_rule    i_rule,
    input  fmpf_pkg::t_in_item i_key,
    output logic               o_hit
);

    logic sip_ok;
    logic dip_ok;
    logic sport_ok;
    logic dport_ok;

    // Per-field compare with wildcard override
    assign sip_ok   = i_rule.src_ip_any || (i_rule.src_ip == i_key.src_ip);
    assign dip_ok   = i_rule.dst_ip_any || (i_rule.dst_ip == i_key.dst_ip);
    assign sport_ok = i_rule.sport_any  || (i_rule.sport  == i_key.sport);
    assign dport_ok = i_rule.dport_any  || (i_rule.dport  == i_key.dport);

    assign o_hit = sip_ok && dip_ok && sport_ok && dport_ok;

endmodule

>>> hdl/first_match_packet_filter_core.sv
// ---------------------------------------------------------------------------
// first_match_packet_filter_core: ordered first-match rule table
// Rules live in one RAM used as a circular table: insert at front moves
// the head pointer back, remove closes the gap by a read/write sweep,
// lookup streams rules out of the RAM one per cycle.
//
//   Channel | Signals                               | Item type
//   --------+---------------------------------------+-----------
//   Request | i_in_valid, o_in_ready, i_in_item     | t_in_item
//   Result  | o_out_valid, i_out_ready, o_out_item  | t_out_item
//
// Lookup reads rules in order from position 0 and stops at the first hit
//   or after the last rule; one RAM read per cycle sets the pace. An empty
//   table gives a block verdict without a scan.
// Remove at index i reads and writes back each later rule, one RAM read and
//   one write per moved rule. Insert, clear and rejected requests need no walk.
// One item at a time; the next is taken while a result waits in the
//   output register. Reset empties the table (count and head only).
// ---------------------------------------------------------------------------
module first_match_packet_filter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fmpf_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fmpf_pkg::t_out_item  o_out_item
);

    localparam int AW = fmpf_pkg::AW;
    localparam int CW = fmpf_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state,    n_state;
    logic [AW-1:0]       r_head,     n_head;
    logic [CW-1:0]       r_count,    n_count;
    logic [CW-1:0]       r_k,        n_k;
    logic                r_rd_vld,   n_rd_vld;
    logic [AW-1:0]       r_rd_k,     n_rd_k;
    fmpf_pkg::t_in_item  r_req,      n_req;
    fmpf_pkg::t_out_item r_rsp,      n_rsp;
    logic                r_out_valid, n_out_valid;
    fmpf_pkg::t_out_item r_out_item, n_out_item;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    fmpf_pkg::t_rule     ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    fmpf_pkg::t_rule     ram_rdata;
    logic                hit;
    logic                accept;
    logic                issue;
    logic                last;
    logic                out_free;
    logic [AW-1:0]       head_dec;

    // Rule storage
    fmpf_ram #(
        .WIDTH (fmpf_pkg::RULE_W),
        .DEPTH (fmpf_pkg::MAX_RULES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Compare the rule coming out of the RAM against the held packet
    fmpf_match u_match (
        .i_rule (ram_rdata),
        .i_key  (r_req),
        .o_hit  (hit)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign issue       = (r_k < r_count);
    assign last        = ((CW'(r_rd_k) + CW'(1)) == r_count);
    assign out_free    = !r_out_valid || i_out_ready;
    assign head_dec    = (r_head == '0) ? AW'(fmpf_pkg::MAX_RULES - 1)
                                        : (r_head - AW'(1));
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_rd_vld    = 1'b0;
        n_rd_k      = r_rd_k;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_waddr   = fmpf_pkg::phys_addr(r_head, r_rd_k - AW'(1));
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = fmpf_pkg::phys_addr(r_head, r_k[AW-1:0]);

        // output register drains independently of the sequencer
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req            = i_in_item;
                    n_rsp            = '0;
                    n_rsp.rule_count = 7'(r_count);
                    n_state          = S_DONE;
                    unique case (i_in_item.req_type)
                        fmpf_pkg::REQ_LOOKUP: begin
                            n_k = '0;
                            if (r_count == '0) begin
                                n_rsp.verdict_block = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        fmpf_pkg::REQ_INSERT: begin
                            if (int'(r_count) >= fmpf_pkg::MAX_RULES) begin
                                n_rsp.status = fmpf_pkg::ST_FULL;
                            end else begin
                                n_head           = head_dec;
                                ram_we           = 1'b1;
                                ram_waddr        = head_dec;
                                ram_wdata        = fmpf_pkg::make_rule(i_in_item);
                                n_count          = r_count + CW'(1);
                                n_rsp.rule_count = 7'(r_count + CW'(1));
                            end
                        end
                        fmpf_pkg::REQ_REMOVE: begin
                            if (int'(i_in_item.rule_index) >= int'(r_count)) begin
                                n_rsp.status = fmpf_pkg::ST_RANGE;
                            end else begin
                                n_k     = CW'(i_in_item.rule_index) + CW'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        fmpf_pkg::REQ_CLEAR: begin
                            n_count          = '0;
                            n_rsp.rule_count = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // stream rules out, stop at the first hit or after the last
            S_SCAN: begin
                if (r_rd_vld && (hit || last)) begin
                    n_rsp.verdict_block = hit ? ram_rdata.block : 1'b1;
                    n_rsp.matched       = hit;
                    n_rsp.match_index   = hit ? 6'(r_rd_k) : 6'd0;
                    n_state             = S_DONE;
                end else if (issue) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_k   = r_k[AW-1:0];
                    n_k      = r_k + CW'(1);
                end
            end

            // move each rule after the removed one forward by one place
            S_SHIFT: begin
                if (issue) begin
                    ram_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_k   = r_k[AW-1:0];
                    n_k      = r_k + CW'(1);
                end
                if (r_rd_vld) begin
                    ram_we = 1'b1;
                end
                if (!issue && !r_rd_vld) begin
                    n_count          = r_count - CW'(1);
                    n_rsp.rule_count = 7'(r_count - CW'(1));
                    n_state          = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_rsp;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_rd_k     <= n_rd_k;
        r_req      <= n_req;
        r_rsp      <= n_rsp;
        r_out_item <= n_out_item;
    end

    // Table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= fmpf_pkg::MAX_RULES)
        else $error("rule count above capacity");

    // A lookup never writes the table
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !ram_we)
        else $error("write during lookup scan");

    // An accepted insert with room grows the table by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in_item.req_type == fmpf_pkg::REQ_INSERT) &&
         (int'(r_count) < fmpf_pkg::MAX_RULES))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the table");

    // A reported match lies inside the table
    a_match_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.matched) |->
        (int'(o_out_item.match_index) < int'(o_out_item.rule_count)))
        else $error("match index outside table");

    // A read is only pending while the table is being walked
    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == S_SCAN) || (r_state == S_SHIFT)))
        else $error("RAM read outside scan or shift");

endmodule
